@@ hdl/ohlc_minute_bar_builder_macros.svh @@
// Assertion macros shared by the OHLC bar builder checkers.
`ifndef OHLC_MINUTE_BAR_BUILDER_MACROS_SVH
`define OHLC_MINUTE_BAR_BUILDER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OHLC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OHLC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ohlc_pkg.sv @@
// Types, constants and word layouts shared by the OHLC minute bar builder.
`default_nettype none

package ohlc_pkg;

  localparam int unsigned PRICE_BITS_DEF  = 32;
  localparam int unsigned VOLUME_BITS_DEF = 32;

  localparam logic [10:0] MINUTE_MAX = 11'd1439;
  localparam logic [39:0] VOL_MAX    = 40'hFF_FFFF_FFFF;

  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [0:0] {
    KIND_TRADE = 1'b0,
    KIND_FLUSH = 1'b1
  } ohlc_kind_e;

  // Input word, first field in the highest bits.
  typedef struct packed {
    logic [31:0] trade_volume;
    logic [31:0] trade_price;
    logic [10:0] trade_minute;
    logic [15:0] trade_day;
  } ohlc_trade_t;

  // Output word, first field in the highest bits.
  typedef struct packed {
    logic [10:0] repeat_count;
    logic [39:0] bar_volume;
    logic [31:0] close_price;
    logic [31:0] low_price;
    logic [31:0] high_price;
    logic [31:0] open_price;
    logic [10:0] bar_minute;
    logic [15:0] bar_day;
    logic [31:0] bar_index;
  } ohlc_bar_data_t;

  typedef struct packed {
    logic           rejected;
    logic           last;
    ohlc_bar_data_t data;
  } ohlc_result_t;

  // Which result slots an update fills this cycle.
  typedef struct packed {
    logic first;
    logic second;
  } ohlc_push_t;

  localparam int unsigned IN_DATA_BITS   = $bits(ohlc_trade_t);
  localparam int unsigned IN_TDATA_BITS  = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_BITS  = $bits(ohlc_bar_data_t);
  localparam int unsigned OUT_TDATA_BITS = ((OUT_DATA_BITS + 7) / 8) * 8;

endpackage

`default_nettype wire

@@ hdl/ohlc_minute_bar_builder.sv @@
// Top level of the one-minute OHLCV candle builder.
`default_nettype none

// Builds one-minute open/high/low/close/volume candles from a time-ordered trade stream.
// Each slave word is a trade (tuser = 0) or an end-of-stream flush (tuser = 1). Every
// closed candle leaves as one master word; a jump of several minutes within a day adds
// a second word, a run record standing for the flat zero-volume minutes in between at
// the previous close. Trades earlier than the open candle are dropped and answered by a
// word with tuser (rejected) set. The block takes one word per cycle unless the queue is
// short of room: the word is held in an input register, the candle state updates from it
// once the queue has space for two results, and the results land in a four-word output
// queue that feeds the master side. The input side backs off while the queue holds
// more than two words, which only comes into play when the sink stalls or run records
// pile up, since the master side drains one word per cycle. Prices are kept in the low
// PRICE_BITS bits, volumes in the low VOLUME_BITS bits of the trade, and candle volume
// saturates at 2^40-1.
module ohlc_minute_bar_builder #(
  parameter int unsigned PRICE_BITS  = ohlc_pkg::PRICE_BITS_DEF,
  parameter int unsigned VOLUME_BITS = ohlc_pkg::VOLUME_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // trade_day[15:0], trade_minute[26:16], trade_price[58:27], trade_volume[90:59]
  input  logic [ohlc_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,
  // kind[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // bar_index[31:0], bar_day[47:32], bar_minute[58:48], open_price[90:59],
  // high_price[122:91], low_price[154:123], close_price[186:155],
  // bar_volume[226:187], repeat_count[237:227]
  output logic [ohlc_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  // rejected[0]
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);
  import ohlc_pkg::*;

  logic         in_valid_q, in_valid_d;
  ohlc_kind_e   in_kind_q;
  ohlc_trade_t  in_trade_q;
  logic         accept;
  logic         fire;
  logic         room;
  ohlc_push_t   push;
  ohlc_result_t res0;
  ohlc_result_t res1;

  // Process the held word once the queue has space for two results.
  assign fire          = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || fire;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = accept || (in_valid_q && !fire);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Payload of the input register, loaded on accept only.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_kind_q  <= ohlc_kind_e'(s_axis_tuser);
      in_trade_q <= ohlc_trade_t'(s_axis_tdata[IN_DATA_BITS-1:0]);
    end
  end

  ohlc_bar_update #(
    .PRICE_BITS  (PRICE_BITS),
    .VOLUME_BITS (VOLUME_BITS)
  ) u_update (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .kind_i  (in_kind_q),
    .trade_i (in_trade_q),
    .push_o  (push),
    .res0_o  (res0),
    .res1_o  (res1)
  );

  ohlc_result_fifo u_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .res0_i        (res0),
    .res1_i        (res1),
    .room_o        (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ hdl/ohlc_bar_update.sv @@
// Candle state and the combinational update that turns one item into up to two results.
`default_nettype none

module ohlc_bar_update #(
  parameter int unsigned PRICE_BITS  = ohlc_pkg::PRICE_BITS_DEF,
  parameter int unsigned VOLUME_BITS = ohlc_pkg::VOLUME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  ohlc_pkg::ohlc_kind_e kind_i,
  input  ohlc_pkg::ohlc_trade_t trade_i,
  output ohlc_pkg::ohlc_push_t  push_o,
  output ohlc_pkg::ohlc_result_t res0_o,
  output ohlc_pkg::ohlc_result_t res1_o
);
  import ohlc_pkg::*;

  localparam int unsigned PW = (PRICE_BITS < 32) ? PRICE_BITS : 32;
  localparam int unsigned VW = (VOLUME_BITS < 32) ? VOLUME_BITS : 32;

  logic          open_q, open_d;
  logic [15:0]   day_q, day_d;
  logic [10:0]   minute_q, minute_d;
  logic [PW-1:0] opx_q, opx_d;
  logic [PW-1:0] high_q, high_d;
  logic [PW-1:0] low_q, low_d;
  logic [PW-1:0] close_q, close_d;
  logic [39:0]   vol_q, vol_d;
  logic [31:0]   index_q, index_d;

  logic [10:0]   minute_in;
  logic [PW-1:0] price_in;
  logic [VW-1:0] vol_in;
  logic [40:0]   vol_sum;
  logic [10:0]   step;
  logic [10:0]   gap;
  logic          earlier;
  ohlc_result_t  cur_res;

  assign minute_in = (trade_i.trade_minute > MINUTE_MAX) ? MINUTE_MAX : trade_i.trade_minute;
  assign price_in  = trade_i.trade_price[PW-1:0];
  assign vol_in    = trade_i.trade_volume[VW-1:0];
  assign vol_sum   = {1'b0, vol_q} + 41'(vol_in);
  assign step      = minute_in - minute_q;
  assign gap       = step - 11'd1;
  assign earlier   = (trade_i.trade_day < day_q) ||
                     ((trade_i.trade_day == day_q) && (minute_in < minute_q));

  always_comb begin
    cur_res                   = '0;
    cur_res.last              = 1'b1;
    cur_res.data.bar_index    = index_q;
    cur_res.data.bar_day      = day_q;
    cur_res.data.bar_minute   = minute_q;
    cur_res.data.open_price   = 32'(opx_q);
    cur_res.data.high_price   = 32'(high_q);
    cur_res.data.low_price    = 32'(low_q);
    cur_res.data.close_price  = 32'(close_q);
    cur_res.data.bar_volume   = vol_q;
    cur_res.data.repeat_count = 11'd1;
  end

  always_comb begin
    open_d   = open_q;
    day_d    = day_q;
    minute_d = minute_q;
    opx_d    = opx_q;
    high_d   = high_q;
    low_d    = low_q;
    close_d  = close_q;
    vol_d    = vol_q;
    index_d  = index_q;
    push_o   = '0;
    res0_o   = cur_res;
    res1_o   = '0;
    if (fire_i) begin
      if (kind_i == KIND_FLUSH) begin
        push_o.first = open_q;
        open_d   = 1'b0;
        day_d    = '0;
        minute_d = '0;
        opx_d    = '0;
        high_d   = '0;
        low_d    = '0;
        close_d  = '0;
        vol_d    = '0;
        index_d  = '0;
      end else if (open_q && earlier) begin
        // Drop the trade, report it.
        push_o.first    = 1'b1;
        res0_o          = '0;
        res0_o.rejected = 1'b1;
        res0_o.last     = 1'b1;
      end else if (open_q && (trade_i.trade_day == day_q) && (minute_in == minute_q)) begin
        if (vol_q == '0) begin
          opx_d   = price_in;
          high_d  = price_in;
          low_d   = price_in;
          close_d = price_in;
          vol_d   = 40'(vol_in);
        end else begin
          close_d = price_in;
          if (price_in > high_q) begin
            high_d = price_in;
          end
          if (price_in < low_q) begin
            low_d = price_in;
          end
          vol_d = vol_sum[40] ? VOL_MAX : vol_sum[39:0];
        end
      end else begin
        if (open_q) begin
          push_o.first = 1'b1;
          if (trade_i.trade_day == day_q) begin
            index_d = index_q + 32'(step);
            if (gap != '0) begin
              // Close the candle, then a run of flat candles at the old close.
              push_o.second                = 1'b1;
              res0_o.last                  = 1'b0;
              res1_o.last                  = 1'b1;
              res1_o.data.bar_index        = index_q + 32'd1;
              res1_o.data.bar_day          = day_q;
              res1_o.data.bar_minute       = minute_q + 11'd1;
              res1_o.data.open_price       = 32'(close_q);
              res1_o.data.high_price       = 32'(close_q);
              res1_o.data.low_price        = 32'(close_q);
              res1_o.data.close_price      = 32'(close_q);
              res1_o.data.repeat_count     = gap;
            end
          end else begin
            index_d = index_q + 32'd1;
          end
        end
        open_d   = 1'b1;
        day_d    = trade_i.trade_day;
        minute_d = minute_in;
        opx_d    = price_in;
        high_d   = price_in;
        low_d    = price_in;
        close_d  = price_in;
        vol_d    = 40'(vol_in);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      day_q    <= '0;
      minute_q <= '0;
      opx_q    <= '0;
      high_q   <= '0;
      low_q    <= '0;
      close_q  <= '0;
      vol_q    <= '0;
      index_q  <= '0;
    end else begin
      open_q   <= open_d;
      day_q    <= day_d;
      minute_q <= minute_d;
      opx_q    <= opx_d;
      high_q   <= high_d;
      low_q    <= low_d;
      close_q  <= close_d;
      vol_q    <= vol_d;
      index_q  <= index_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ohlc_result_fifo.sv @@
// Small result queue: takes up to two words a cycle, hands one out a cycle while the sink is ready.
`default_nettype none

module ohlc_result_fifo (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  ohlc_pkg::ohlc_push_t                    push_i,
  input  ohlc_pkg::ohlc_result_t                  res0_i,
  input  ohlc_pkg::ohlc_result_t                  res1_i,
  output logic                                    room_o,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [ohlc_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata,
  output logic                                    m_axis_tuser,
  output logic                                    m_axis_tlast
);
  import ohlc_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  ohlc_result_t mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] wr_ptr_next;
  logic             pop;

  assign pop          = m_axis_tvalid && m_axis_tready;
  assign wr_ptr_next  = wr_ptr_q + PTR_W'(1);
  assign room_o       = (count_q <= CNT_W'(FIFO_DEPTH - 2));

  assign m_axis_tvalid = (count_q != '0);
  assign m_axis_tdata  = OUT_TDATA_BITS'(mem_q[rd_ptr_q].data);
  assign m_axis_tuser  = mem_q[rd_ptr_q].rejected;
  assign m_axis_tlast  = mem_q[rd_ptr_q].last;

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.first) + PTR_W'(push_i.second);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + CNT_W'(push_i.first) + CNT_W'(push_i.second) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      if (push_i.first && (wr_ptr_q == PTR_W'(i))) begin
        mem_q[i] <= res0_i;
      end else if (push_i.second && (wr_ptr_next == PTR_W'(i))) begin
        mem_q[i] <= res1_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/ohlc_port_checker.sv @@
// Port-level checks for the OHLC minute bar builder, bound to the top level.
`default_nettype none

`include "ohlc_minute_bar_builder_macros.svh"

module ohlc_port_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tready,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready,
  input logic [ohlc_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata,
  input logic                                m_axis_tuser,
  input logic                                m_axis_tlast
);
  import ohlc_pkg::*;

  ohlc_bar_data_t bar;

  assign bar = ohlc_bar_data_t'(m_axis_tdata[OUT_DATA_BITS-1:0]);

  // A stalled result word holds.
  `OHLC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}), "stalled result word changed")

  // With nothing queued on the result side, the input side is open.
  `OHLC_ASSERT_IMP(a_idle_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input stalled with an empty result queue")

  // A rejection is a lone, otherwise empty word.
  `OHLC_ASSERT_IMP(a_reject_empty, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata == '0), "rejection word not empty")

  // Every accepted candle or run stands for at least one minute.
  `OHLC_ASSERT_IMP(a_repeat_nonzero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, bar.repeat_count != '0, "candle word with zero repeat count")

  // Only a closed candle ahead of its run record is not last.
  `OHLC_ASSERT_IMP(a_first_of_pair, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, !m_axis_tuser && (bar.repeat_count == 11'd1), "non-last word is not a single candle")

endmodule

bind ohlc_minute_bar_builder ohlc_port_checker u_ohlc_port_checker (.*);

`default_nettype wire
